[src/efxc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efxc_pkg
// Shared constants, types and the byte escape function of the framer.
// ----------------------------------------------------------------------------
package efxc_pkg;

    // Flag and escape codes on the wire
    localparam logic [7:0] FLAG_START = 8'h5B;
    localparam logic [7:0] FLAG_END   = 8'h5D;
    localparam logic [7:0] ESC_A      = 8'h5A;
    localparam logic [7:0] ESC_E      = 8'h5E;
    localparam logic [7:0] ESC_ONE    = 8'h01;
    localparam logic [7:0] ESC_TWO    = 8'h02;

    // Most wire bytes one body byte can cause: start, 2 body, 2 check, end
    localparam int MAX_WIRE = 6;
    localparam int CNT_W    = 3;
    localparam int IDX_W    = 3;

    // One escaped byte: one or two wire bytes
    typedef struct packed {
        logic       pair;
        logic [7:0] b0;
        logic [7:0] b1;
    } esc_t;

    // Wire bytes caused by one body byte
    typedef struct packed {
        logic [MAX_WIRE-1:0][7:0] bytes;
        logic [CNT_W-1:0]         count;
        logic                     closes;
    } wire_run_t;

    // Map a raw byte to its escaped form
    function automatic esc_t escape_byte(input logic [7:0] b);
        esc_t e;
        e.pair = 1'b1;
        e.b1   = ESC_ONE;
        case (b)
            FLAG_START:
            begin
                e.b0 = ESC_A;
                e.b1 = ESC_ONE;
            end
            ESC_A:
            begin
                e.b0 = ESC_A;
                e.b1 = ESC_TWO;
            end
            FLAG_END:
            begin
                e.b0 = ESC_E;
                e.b1 = ESC_ONE;
            end
            ESC_E:
            begin
                e.b0 = ESC_E;
                e.b1 = ESC_TWO;
            end
            default:
            begin
                e.pair = 1'b0;
                e.b0   = b;
            end
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

[src/efxc_expand.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efxc_expand
// Holds the frame state and expands one body byte into its run of wire bytes.
// ----------------------------------------------------------------------------
module efxc_expand
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire logic [7:0]           body_byte,
    input  wire logic                 body_last,
    output efxc_pkg::wire_run_t       run
);

    logic [7:0] check_accum_reg;
    logic       frame_open_reg;
    logic [7:0] check_next;
    efxc_pkg::esc_t body_esc;
    efxc_pkg::esc_t check_esc;

    // Fold the byte into the check and escape both
    assign check_next = check_accum_reg ^ body_byte;
    assign body_esc   = efxc_pkg::escape_byte(body_byte);
    assign check_esc  = efxc_pkg::escape_byte(check_next);

    // Lay out the run of wire bytes
    always_comb
    begin
        logic [efxc_pkg::CNT_W-1:0] p;
        p         = '0;
        run.bytes = '0;
        if (!frame_open_reg)
        begin
            run.bytes[p] = efxc_pkg::FLAG_START;
            p = p + 1'b1;
        end
        run.bytes[p] = body_esc.b0;
        p = p + 1'b1;
        if (body_esc.pair)
        begin
            run.bytes[p] = body_esc.b1;
            p = p + 1'b1;
        end
        if (body_last)
        begin
            run.bytes[p] = check_esc.b0;
            p = p + 1'b1;
            if (check_esc.pair)
            begin
                run.bytes[p] = check_esc.b1;
                p = p + 1'b1;
            end
            run.bytes[p] = efxc_pkg::FLAG_END;
            p = p + 1'b1;
        end
        run.count  = p;
        run.closes = body_last;
    end

    // Advance the frame state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_accum_reg <= '0;
            frame_open_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (body_last)
            begin
                check_accum_reg <= '0;
                frame_open_reg  <= 1'b0;
            end
            else
            begin
                check_accum_reg <= check_next;
                frame_open_reg  <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[src/escape_framer_xor_check.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escape_framer_xor_check
// Byte-stuffing serial framer with a running XOR check byte.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries raw frame body bytes, s_tlast on the final byte.
//   Master channel carries wire bytes: 0x5B before the first byte of a frame,
//   each body byte escaped (5B->5A 01, 5A->5A 02, 5D->5E 01, 5E->5E 02),
//   and after the final byte the escaped XOR check and the end flag 0x5D.
//   m_tlast marks the last wire byte caused by one input beat; m_tuser marks
//   the end flag.
// Timing:
//   An accepted beat is expanded in its accept cycle into a run buffer of up
//   to six bytes; the buffer feeds the output register one byte per cycle
//   unless the master stalls. The first wire byte goes via the buffer and then
//   the output register. A beat holds the buffer until its wire bytes
//   (1 to 6) move on, so the output port, at one byte a cycle, sets the
//   throughput: a new beat is taken as the buffer hands over its final byte.
// Reset clears the check and frame state and empties buffer and output.
// A stalled master holds the output register and then the buffer, and the
// slave side backs up behind them with no loss.
// ----------------------------------------------------------------------------
module escape_framer_xor_check
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] body_byte
    input  wire logic       s_tlast,   // body_last
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,   // [7:0] wire_byte
    output      logic       m_tlast,   // run_last
    output      logic       m_tuser    // [0] frame_end
);

    efxc_pkg::wire_run_t run;
    efxc_pkg::wire_run_t run_reg;
    logic                buf_valid_reg;
    logic [efxc_pkg::IDX_W-1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_end_reg;
    logic       take;
    logic       move;
    logic       at_end;
    logic       buf_done;

    efxc_expand u_expand
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .body_byte (s_tdata),
        .body_last (s_tlast),
        .run       (run)
    );

    // Handshake between buffer and output register
    assign move     = buf_valid_reg && (!out_valid_reg || m_tready);
    assign at_end   = (idx_reg == (run_reg.count - 1'b1));
    assign buf_done = move && at_end;
    assign s_tready = !buf_valid_reg || buf_done;
    assign take     = s_tvalid && s_tready;

    // Load the run buffer, step through it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (take)
        begin
            buf_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (buf_done)
        begin
            buf_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Hold the run payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            run_reg <= run;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_byte_reg <= run_reg.bytes[idx_reg];
            out_last_reg <= at_end;
            out_end_reg  <= at_end && run_reg.closes;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

endmodule
`default_nettype wire
